@@ rtl/core/stm_pkg.sv @@
// Shared types, constants and helpers for the stepper trapezoid move generator.
// No dependencies; used by every module in rtl/core except stm_div.
package stm_pkg;

  localparam int unsigned STEP_WIDTH_DEF    = 16;
  localparam int unsigned VEL_FRAC_BITS_DEF = 8;

  localparam int unsigned ACC_W   = 20;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned AXIS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [ACC_W-1:0] ACC_RST      = 20'd5000;
  localparam logic [SPD_W-1:0] MIN_SPD_RST  = 16'd200;
  localparam logic [ACC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [1:0]       FAIL_LIMIT   = 2'd3;
  localparam logic [PER_W-1:0] PER_MAX      = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEALTH = 2'd2;

  // commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // axes
  localparam logic [AXIS_W-1:0] AX_PULLEY   = 2'd0;
  localparam logic [AXIS_W-1:0] AX_SELECTOR = 2'd1;
  localparam logic [AXIS_W-1:0] AX_IDLER    = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_RUNNING   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE_OK   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DONE_NOTR = 3'd2;
  localparam logic [STAT_W-1:0] ST_STALL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_REHOME    = 3'd4;
  localparam logic [STAT_W-1:0] ST_UNRECOV   = 3'd5;
  localparam logic [STAT_W-1:0] ST_IDLE      = 3'd6;

  // ramp phases
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;

  typedef struct packed {
    logic take;         // input request accepted
    logic load_now;     // result of the accepted request is loaded into the output register this cycle
    logic div_start;
    logic div_accel;    // 1: dividend is the acceleration term, 0: period term
    logic store_period;
    logic store_dv;
    logic finish;       // commit ramp update and load the step result
  } stm_cmd_t;

  typedef struct packed {
    logic long_step;    // accepted request needs both divisions
    logic div_done;
  } stm_stat_t;

  function automatic logic dir_level(input logic [AXIS_W-1:0] axis, input logic neg);
    logic lvl;
    case (axis)
      AX_PULLEY:   lvl = neg;
      AX_SELECTOR: lvl = ~neg;
      AX_IDLER:    lvl = ~neg;
      default:     lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

@@ rtl/core/stm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by stm_datapath for the period and velocity-step terms.
module stm_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned VW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dsr_q, dsr_d;
  logic          done_q, done_d;
  logic [VW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(DW);
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
    end else if (cnt_q != '0) begin
      rem_d  = ge ? VW'(trial - {1'b0, dsr_q}) : VW'(trial);
      quo_d  = {quo_q[DW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/stm_datapath.sv @@
// Move state, configuration registers, ramp arithmetic and result register.
// Depends on stm_pkg and stm_div.
module stm_datapath #(
  parameter int unsigned STEP_WIDTH    = stm_pkg::STEP_WIDTH_DEF,
  parameter int unsigned VEL_FRAC_BITS = stm_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stm_pkg::stm_cmd_t             cmd_i,
  output stm_pkg::stm_stat_t            stat_o,
  input  logic                          cfg_we_i,
  input  logic [stm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stm_pkg::ACC_W-1:0]     cfg_data_i,
  input  logic                          in_cmd_i,
  input  logic [stm_pkg::IN_DATA_W-1:0] in_data_i,
  output logic [stm_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic [stm_pkg::STAT_W-1:0]    out_status_o
);

  localparam int unsigned F  = VEL_FRAC_BITS;
  localparam int unsigned SW = STEP_WIDTH;
  localparam int unsigned VW = stm_pkg::SPD_W + F;
  localparam int unsigned DW = stm_pkg::ACC_W + 2 * F;

  // input fields
  logic [1:0]  in_axis;
  logic [15:0] in_count;
  logic [15:0] in_peak;
  logic        in_rehome, in_use_stall, in_use_fil, in_use_ir;
  logic        in_stall, in_loaded, in_ir;

  assign in_axis      = in_data_i[1:0];
  assign in_count     = in_data_i[17:2];
  assign in_peak      = in_data_i[33:18];
  assign in_rehome    = in_data_i[34];
  assign in_use_stall = in_data_i[35];
  assign in_use_fil   = in_data_i[36];
  assign in_use_ir    = in_data_i[37];
  assign in_stall     = in_data_i[38];
  assign in_loaded    = in_data_i[39];
  assign in_ir        = in_data_i[40];

  logic [stm_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [stm_pkg::SPD_W-1:0] min_spd_q, min_spd_d;
  logic                      stealth_q, stealth_d;

  logic          busy_q, busy_d;
  logic [1:0]    axis_q, axis_d;
  logic          neg_q, neg_d;
  logic          opt_rh_q, opt_rh_d, opt_st_q, opt_st_d;
  logic          opt_fil_q, opt_fil_d, opt_ir_q, opt_ir_d;
  logic [SW-1:0] rem_q, rem_d, cmp_q, cmp_d, rsteps_q, rsteps_d;
  logic [1:0]    phase_q, phase_d;
  logic [VW-1:0] vel_q, vel_d;
  logic [15:0]   lim_q, lim_d;
  logic [1:0]    idl_fail_q, idl_fail_d, sel_fail_q, sel_fail_d;
  logic [15:0]   per_q, per_d;
  logic [DW-1:0] dv_q, dv_d;

  logic          o_pulse_q, o_pulse_d, o_dir_q, o_dir_d, o_ir_q, o_ir_d;
  logic [1:0]    o_axis_q, o_axis_d;
  logic [15:0]   o_per_q, o_per_d;
  logic [2:0]    o_stat_q, o_stat_d;

  logic          div_done;
  logic [DW-1:0] quotient, dividend;

  logic [15:0]   mag, peak_eff, min_eff;
  logic [VW-1:0] vmin, vmax, vdiff;
  logic [DW:0]   vsum;
  logic          neg_in, stall_end, fil_end, ir_end, long_step;

  assign neg_in   = in_count[15];
  assign mag      = neg_in ? 16'(-in_count) : in_count;
  assign peak_eff = (in_peak == '0) ? 16'd1 : in_peak;
  assign min_eff  = (min_spd_q == '0) ? 16'd1 : min_spd_q;
  assign vmin     = {min_eff, F'(0)};
  assign vmax     = {lim_q, F'(0)};
  assign vsum     = (DW+1)'(vel_q) + (DW+1)'(dv_q);
  assign vdiff    = vel_q - VW'(dv_q);

  assign stall_end = opt_st_q & in_stall;
  assign fil_end   = (axis_q == stm_pkg::AX_PULLEY) & opt_fil_q & (neg_q ^ in_loaded);
  assign ir_end    = (axis_q == stm_pkg::AX_PULLEY) & opt_ir_q & in_ir;
  assign long_step = (in_cmd_i == stm_pkg::CMD_STEP) & busy_q & ~stall_end & ~fil_end
                     & ~ir_end;

  assign stat_o.long_step = long_step;
  assign stat_o.div_done  = div_done;

  assign dividend = cmd_i.div_accel ? (DW'(acc_q) << (2 * F))
                                    : (DW'(stm_pkg::USEC_PER_SEC) << F);

  stm_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (vel_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    acc_d      = acc_q;
    min_spd_d  = min_spd_q;
    stealth_d  = stealth_q;
    busy_d     = busy_q;
    axis_d     = axis_q;
    neg_d      = neg_q;
    opt_rh_d   = opt_rh_q;
    opt_st_d   = opt_st_q;
    opt_fil_d  = opt_fil_q;
    opt_ir_d   = opt_ir_q;
    rem_d      = rem_q;
    cmp_d      = cmp_q;
    rsteps_d   = rsteps_q;
    phase_d    = phase_q;
    vel_d      = vel_q;
    lim_d      = lim_q;
    idl_fail_d = idl_fail_q;
    sel_fail_d = sel_fail_q;
    per_d      = per_q;
    dv_d       = dv_q;
    o_pulse_d  = o_pulse_q;
    o_axis_d   = o_axis_q;
    o_dir_d    = o_dir_q;
    o_per_d    = o_per_q;
    o_stat_d   = o_stat_q;
    o_ir_d     = o_ir_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        stm_pkg::CFG_ACCEL:   acc_d     = cfg_data_i;
        stm_pkg::CFG_MIN_SPD: min_spd_d = cfg_data_i[15:0];
        stm_pkg::CFG_STEALTH: stealth_d = cfg_data_i[0];
        default: ;
      endcase
    end

    if (cmd_i.take) begin
      o_pulse_d = 1'b0;
      o_axis_d  = '0;
      o_dir_d   = 1'b0;
      o_per_d   = '0;
      o_ir_d    = 1'b0;
      if (in_cmd_i == stm_pkg::CMD_START) begin
        axis_d    = in_axis;
        neg_d     = neg_in;
        opt_rh_d  = in_rehome & ~stealth_q;
        opt_st_d  = in_use_stall;
        opt_fil_d = in_use_fil;
        opt_ir_d  = in_use_ir;
        rem_d     = SW'(mag);
        cmp_d     = '0;
        rsteps_d  = '0;
        phase_d   = stm_pkg::PH_ACCEL;
        vel_d     = vmin;
        lim_d     = peak_eff;
        busy_d    = (SW'(mag) != '0) && (in_axis != 2'd3);
        o_axis_d  = in_axis;
        o_dir_d   = stm_pkg::dir_level(in_axis, neg_in);
        o_stat_d  = busy_d ? stm_pkg::ST_RUNNING
                  : ((in_use_fil | in_use_ir) ? stm_pkg::ST_DONE_NOTR : stm_pkg::ST_DONE_OK);
      end else if (!busy_q) begin
        o_stat_d = stm_pkg::ST_IDLE;
      end else begin
        o_pulse_d = 1'b1;
        o_axis_d  = axis_q;
        o_dir_d   = stm_pkg::dir_level(axis_q, neg_q);
        o_stat_d  = stm_pkg::ST_DONE_OK;
        if (stall_end) begin
          busy_d = 1'b0;
          if (axis_q == stm_pkg::AX_PULLEY || !opt_rh_q) begin
            o_stat_d = stm_pkg::ST_STALL;
          end else if (axis_q == stm_pkg::AX_IDLER) begin
            if (idl_fail_q != stm_pkg::FAIL_LIMIT) begin
              idl_fail_d = idl_fail_q + 1'b1;
              o_stat_d   = stm_pkg::ST_REHOME;
            end else begin
              o_stat_d = stm_pkg::ST_UNRECOV;
            end
          end else begin
            if (sel_fail_q != stm_pkg::FAIL_LIMIT) begin
              sel_fail_d = sel_fail_q + 1'b1;
              o_stat_d   = stm_pkg::ST_REHOME;
            end else begin
              o_stat_d = stm_pkg::ST_UNRECOV;
            end
          end
        end else if (fil_end) begin
          busy_d = 1'b0;
        end else if (ir_end) begin
          busy_d = 1'b0;
          o_ir_d = 1'b1;
        end else begin
          rem_d = rem_q - 1'b1;
          cmp_d = cmp_q + 1'b1;
        end
      end
    end

    if (cmd_i.store_period) begin
      per_d = (quotient > DW'(stm_pkg::PER_MAX)) ? stm_pkg::PER_MAX : quotient[15:0];
    end
    if (cmd_i.store_dv) begin
      dv_d = quotient;
    end

    if (cmd_i.finish) begin
      case (phase_q)
        stm_pkg::PH_ACCEL: begin
          if (vsum >= (DW+1)'(vmax)) begin
            rsteps_d = cmp_q;
            phase_d  = stm_pkg::PH_CRUISE;
            vel_d    = vmax;
          end else begin
            vel_d = VW'(vsum);
            if (cmp_q > rem_q) begin
              rsteps_d = cmp_q;
              phase_d  = stm_pkg::PH_DECEL;
            end
          end
        end
        stm_pkg::PH_CRUISE: begin
          if (rem_q <= rsteps_q) phase_d = stm_pkg::PH_DECEL;
        end
        stm_pkg::PH_DECEL: begin
          if (dv_q >= DW'(vel_q) || vdiff < vmin) vel_d = vmin;
          else vel_d = vdiff;
        end
        default: ;
      endcase
      o_pulse_d = 1'b1;
      o_axis_d  = axis_q;
      o_dir_d   = stm_pkg::dir_level(axis_q, neg_q);
      o_per_d   = per_q;
      o_ir_d    = 1'b0;
      if (rem_q == '0) begin
        busy_d   = 1'b0;
        o_stat_d = (opt_fil_q | opt_ir_q) ? stm_pkg::ST_DONE_NOTR : stm_pkg::ST_DONE_OK;
      end else begin
        o_stat_d = stm_pkg::ST_RUNNING;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= stm_pkg::ACC_RST;
      min_spd_q  <= stm_pkg::MIN_SPD_RST;
      stealth_q  <= 1'b0;
      busy_q     <= 1'b0;
      axis_q     <= '0;
      neg_q      <= 1'b0;
      opt_rh_q   <= 1'b0;
      opt_st_q   <= 1'b0;
      opt_fil_q  <= 1'b0;
      opt_ir_q   <= 1'b0;
      rem_q      <= '0;
      cmp_q      <= '0;
      rsteps_q   <= '0;
      phase_q    <= stm_pkg::PH_ACCEL;
      vel_q      <= {stm_pkg::MIN_SPD_RST, F'(0)};
      lim_q      <= '0;
      idl_fail_q <= '0;
      sel_fail_q <= '0;
    end else begin
      acc_q      <= acc_d;
      min_spd_q  <= min_spd_d;
      stealth_q  <= stealth_d;
      busy_q     <= busy_d;
      axis_q     <= axis_d;
      neg_q      <= neg_d;
      opt_rh_q   <= opt_rh_d;
      opt_st_q   <= opt_st_d;
      opt_fil_q  <= opt_fil_d;
      opt_ir_q   <= opt_ir_d;
      rem_q      <= rem_d;
      cmp_q      <= cmp_d;
      rsteps_q   <= rsteps_d;
      phase_q    <= phase_d;
      vel_q      <= vel_d;
      lim_q      <= lim_d;
      idl_fail_q <= idl_fail_d;
      sel_fail_q <= sel_fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    per_q     <= per_d;
    dv_q      <= dv_d;
    o_pulse_q <= o_pulse_d;
    o_axis_q  <= o_axis_d;
    o_dir_q   <= o_dir_d;
    o_per_q   <= o_per_d;
    o_stat_q  <= o_stat_d;
    o_ir_q    <= o_ir_d;
  end

  assign out_data_o   = {3'b000, o_ir_q, o_per_q, o_dir_q, o_axis_q, o_pulse_q};
  assign out_status_o = o_stat_q;

endmodule

@@ rtl/core/stm_ctrl.sv @@
// Sequencing state machine: request intake, the two divisions, result hand-off.
// Depends on stm_pkg.
module stm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  stm_pkg::stm_stat_t stat_i,
  output stm_pkg::stm_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIVP = 4'b0010,
    S_DIVA = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e st_q, st_d;
  logic   ovalid_q, ovalid_d;
  logic   slot_free;

  assign slot_free  = ~ovalid_q | out_ready_i;
  assign in_ready_o = (st_q == S_IDLE) & slot_free;

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    cmd_o.take = in_valid_i & in_ready_o;
    case (st_q)
      S_IDLE: begin
        if (cmd_o.take) begin
          if (stat_i.long_step) begin
            cmd_o.div_start = 1'b1;
            st_d = S_DIVP;
          end else begin
            cmd_o.load_now = 1'b1;
          end
        end
      end
      S_DIVP: begin
        if (stat_i.div_done) begin
          cmd_o.store_period = 1'b1;
          cmd_o.div_start    = 1'b1;
          cmd_o.div_accel    = 1'b1;
          st_d = S_DIVA;
        end
      end
      S_DIVA: begin
        if (stat_i.div_done) begin
          cmd_o.store_dv = 1'b1;
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_now || cmd_o.finish) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
    else ovalid_d = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

@@ rtl/core/stepper_trapezoid_move_with_stall.sv @@
// Top level of the trapezoidal stepper move generator, one axis per move.
// Depends on stm_pkg, stm_ctrl, stm_datapath (and stm_div below it).
//
// channel  | dir | handshake                    | contents
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser command, tdata move/step fields
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser status, tdata pulse fields
// cfg      | in  | cfg_valid_i/cfg_ready_o      | register index, write data
//
// Start, idle-step and early-ending step requests: result in the cycle after acceptance.
// A normal step runs the shared bit-serial divider twice (period, then velocity
// step), then commits the ramp update and loads its result.
// Reset gives the power-on registers directly, no clearing sweep.
// A result waits in the output register; a new request is taken while it waits
// only if the result slot frees in that cycle.
module stepper_trapezoid_move_with_stall #(
  parameter int unsigned STEP_WIDTH    = stm_pkg::STEP_WIDTH_DEF,
  parameter int unsigned VEL_FRAC_BITS = stm_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] command
  input  logic                           s_axis_tuser,
  // [1:0] axis, [17:2] step_count, [33:18] peak_speed, [34] rehome_on_fail,
  // [35] use_stall, [36] use_filament_sensor, [37] use_ir_sensor,
  // [38] stall_seen, [39] filament_loaded, [40] ir_seen, [47:41] zero
  input  logic [stm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] status
  output logic [stm_pkg::STAT_W-1:0]     m_axis_tuser,
  // [0] step_pulse, [2:1] pulse_axis, [3] direction_level, [19:4] period_us,
  // [20] ir_consumed, [23:21] zero
  output logic [stm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [stm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stm_pkg::ACC_W-1:0]      cfg_data_i
);

  stm_pkg::stm_cmd_t  cmd;
  stm_pkg::stm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  stm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stm_datapath #(
    .STEP_WIDTH    (STEP_WIDTH),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_idx_i    (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

@@ rtl/core/stm_checker.sv @@
// Port-level checks on the result stream of the stepper move generator.
// Depends on stm_pkg; bound to stepper_trapezoid_move_with_stall.
module stm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [stm_pkg::STAT_W-1:0]     m_axis_tuser,
  input logic [stm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // idle step reports nothing but its status
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == stm_pkg::ST_IDLE |-> m_axis_tdata == '0)
    else $error("idle result carries data");

  // no pulse, no wait
  a_nopulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[19:4] == '0)
    else $error("period without pulse");

  // IR consumption only on a pulsed, successful end
  a_ir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[20] |->
    m_axis_tdata[0] && m_axis_tuser == stm_pkg::ST_DONE_OK && m_axis_tdata[19:4] == '0)
    else $error("bad IR consumed result");

endmodule

bind stepper_trapezoid_move_with_stall stm_checker u_stm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
